/* design/pcmb_pkg.sv */
// pcmb_pkg: shared widths, codes, types and colour helpers for the palette colour-math blender
// no dependencies; imported by pcmb_operand, pcmb_mixer and the top level
`timescale 1ns / 1ps

package pcmb_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam int INDEX_W     = 8;
   localparam int COLOR_W     = 15;
   localparam int COMP_W      = 5;
   localparam int CHAN_W      = 8;
   localparam int INTENSITY_W = 4;
   localparam int PROD_W      = CHAN_W + INTENSITY_W;
   localparam int NUM_CHAN    = 3;

   // floor(x / 15) for x below 4096 as (x * 2185) >> 15
   localparam int DIV15_SHIFT = 15;
   localparam logic [PROD_W-1:0] DIV15_RECIP = PROD_W'(2185);

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = NUM_CHAN * CHAN_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COLOR_W;

   typedef enum logic {
      CMD_BLEND         = 1'b0,
      CMD_PALETTE_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIXED_COLOR   = 2'd0,
      CSR_INTENSITY     = 2'd1,
      CSR_SUBTRACT_MODE = 2'd2
   } csr_index_type;

   // red in the lowest byte
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] fixed_prod_type;

   // per-pixel control decided in the fetch stage
   typedef struct packed {
      logic main_show;
      logic sub_show;
      logic half;
      logic use_fixed;
   } pix_ctl_type;

   function automatic logic [CHAN_W-1:0] expand5(input logic [COMP_W-1:0] c);
      return {c, c[COMP_W-1:2]};
   endfunction

   function automatic rgb_type expand_color(input logic [COLOR_W-1:0] c15);
      rgb_type rgb;
      rgb.red   = expand5(c15[4:0]);
      rgb.green = expand5(c15[9:5]);
      rgb.blue  = expand5(c15[14:10]);
      return rgb;
   endfunction

endpackage

/* design/pcmb_ram.sv */
// pcmb_ram: generic single-write, dual-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module pcmb_ram #(
   parameter int DATA_W = 15,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* design/pcmb_operand.sv */
// pcmb_operand: stage 2, expands, masks and halves main and sub colours or picks fixed colour
// depends on pcmb_pkg (colour expansion, fixed-colour divide by 15)
`timescale 1ns / 1ps

module pcmb_operand (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           in_valid,
   input  pcmb_pkg::pix_ctl_type          in_ctl,
   input  logic [pcmb_pkg::COLOR_W-1:0]   main_color,
   input  logic [pcmb_pkg::COLOR_W-1:0]   sub_color,
   input  pcmb_pkg::fixed_prod_type       fixed_prod,
   output logic                           out_valid,
   output pcmb_pkg::rgb_type              main_rgb,
   output pcmb_pkg::rgb_type              sub_rgb
);
   import pcmb_pkg::*;

   logic    valid_ff;
   rgb_type main_ff, main_in;
   rgb_type sub_ff, sub_in;
   rgb_type main_exp, pal_exp, fixed_rgb;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] fixed_chan;
   logic [NUM_CHAN-1:0][2*PROD_W-1:0] scaled;

   // fixed colour scaled by intensity / 15, floored
   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         scaled[k]     = (2*PROD_W)'(fixed_prod[k]) * (2*PROD_W)'(DIV15_RECIP);
         fixed_chan[k] = scaled[k][DIV15_SHIFT +: CHAN_W];
      end
      fixed_rgb.red   = fixed_chan[0];
      fixed_rgb.green = fixed_chan[1];
      fixed_rgb.blue  = fixed_chan[2];
   end

   always_comb begin
      main_exp = expand_color(main_color);
      pal_exp  = expand_color(sub_color);

      if (!in_ctl.main_show) begin
         main_in = '0;
      end else if (in_ctl.half) begin
         main_in.red   = main_exp.red >> 1;
         main_in.green = main_exp.green >> 1;
         main_in.blue  = main_exp.blue >> 1;
      end else begin
         main_in = main_exp;
      end

      if (!in_ctl.sub_show) begin
         sub_in = '0;
      end else if (in_ctl.use_fixed) begin
         sub_in = fixed_rgb;
      end else if (in_ctl.half) begin
         sub_in.red   = pal_exp.red >> 1;
         sub_in.green = pal_exp.green >> 1;
         sub_in.blue  = pal_exp.blue >> 1;
      end else begin
         sub_in = pal_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         main_ff <= main_in;
         sub_ff  <= sub_in;
      end
   end

   assign out_valid = valid_ff;
   assign main_rgb  = main_ff;
   assign sub_rgb   = sub_ff;

endmodule

/* design/pcmb_mixer.sv */
// pcmb_mixer: last pipeline stage, saturating add or floored subtract into the result register
// depends on pcmb_pkg (rgb type)
`timescale 1ns / 1ps

module pcmb_mixer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  logic              subtract_mode,
   input  pcmb_pkg::rgb_type main_rgb,
   input  pcmb_pkg::rgb_type sub_rgb,
   output logic              out_valid,
   output pcmb_pkg::rgb_type out_rgb
);
   import pcmb_pkg::*;

   logic    valid_ff;
   rgb_type rgb_ff, rgb_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] m, s, r;
   logic [NUM_CHAN-1:0][CHAN_W:0]   sum;

   always_comb begin
      m = {main_rgb.blue, main_rgb.green, main_rgb.red};
      s = {sub_rgb.blue, sub_rgb.green, sub_rgb.red};
      for (int k = 0; k < NUM_CHAN; k++) begin
         sum[k] = {1'b0, m[k]} + {1'b0, s[k]};
         if (subtract_mode) begin
            r[k] = (m[k] > s[k]) ? (m[k] - s[k]) : '0;
         end else begin
            r[k] = sum[k][CHAN_W] ? '1 : sum[k][CHAN_W-1:0];
         end
      end
      rgb_in.red   = r[0];
      rgb_in.green = r[1];
      rgb_in.blue  = r[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         rgb_ff <= rgb_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rgb   = rgb_ff;

endmodule

/* design/palette_color_math_blend_core.sv */
// palette_color_math_blend_core: top level of the palette colour-math blender
// depends on pcmb_pkg, pcmb_ram, pcmb_operand and pcmb_mixer
`timescale 1ns / 1ps

// usage
//   req channel: one beat per item; tuser selects a pixel blend or a palette write
//   rsp channel: one beat per blended pixel, 8-bit red, green and blue
//   csr channel: register writes, always ready; write only while the block is idle
// pipeline
//   stage 1 reads both palette colours from the ram and forms the fixed-colour product
//   stage 2 expands to 8 bits per channel, masks, halves and divides the fixed colour by 15
//   stage 3 does the saturating add or floored subtract into the result register
//   a blend beat passes through the stage 1 registers and palette read data, the stage 2
//   operand registers and the result register before its rsp beat is offered
//   one beat per cycle sustained while rsp_tready stays high; a palette write lands at
//   its accept edge, so a blend in the very next beat already sees the new colour
// reset
//   clears the pipeline valids and the registers (intensity 15, the others 0);
//   palette contents stay undefined until written, no clearing pass
// stalls
//   rsp_tready low holds the result; the stages behind it fill any bubbles and
//   req_tready drops only once all three stages hold a pixel

module palette_color_math_blend_core #(
   parameter int PALETTE_ENTRIES = pcmb_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // main_index[7:0], sub_index[15:8], main_enable[16], sub_enable[17], half_enable[18],
   // palette_address[26:19], palette_data[41:27], zero pad [47:42]
   input  logic [pcmb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd[0]
   input  logic                              req_tuser,
   // rsp
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [pcmb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // csr
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcmb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pcmb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import pcmb_pkg::*;

   localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam logic [INDEX_W:0] ENTRIES_LIM = (INDEX_W + 1)'(PALETTE_ENTRIES);

   // request field positions
   localparam int MAIN_IDX_LSB  = 0;
   localparam int SUB_IDX_LSB   = MAIN_IDX_LSB + INDEX_W;
   localparam int MAIN_EN_BIT   = SUB_IDX_LSB + INDEX_W;
   localparam int SUB_EN_BIT    = MAIN_EN_BIT + 1;
   localparam int HALF_EN_BIT   = SUB_EN_BIT + 1;
   localparam int PAL_ADDR_LSB  = HALF_EN_BIT + 1;
   localparam int PAL_DATA_LSB  = PAL_ADDR_LSB + INDEX_W;

   // request fields
   logic [INDEX_W-1:0] main_index, sub_index, palette_address;
   logic [COLOR_W-1:0] palette_data;
   logic               main_enable, sub_enable, half_enable;
   logic               req_beat, is_blend, is_write;
   logic               main_in_range, sub_in_range, addr_in_range;

   // config registers
   logic [COLOR_W-1:0]     fixed_color_ff;
   logic [INTENSITY_W-1:0] intensity_ff;
   logic                   subtract_mode_ff;

   // pipeline control
   logic adv1, adv2, adv3;
   logic s2_valid;

   // stage 1
   logic           s1_valid_ff, s1_valid_in;
   pix_ctl_type    s1_ctl_ff, s1_ctl_in;
   fixed_prod_type fixed_prod_ff, fixed_prod_in;
   rgb_type        fixed_exp;
   logic [COLOR_W-1:0] main_color, sub_color;

   // stage 2 to 3
   rgb_type s2_main, s2_sub, rsp_rgb;

   // ---------------------------------------------------------------- request decode
   assign main_index      = req_tdata[MAIN_IDX_LSB +: INDEX_W];
   assign sub_index       = req_tdata[SUB_IDX_LSB +: INDEX_W];
   assign main_enable     = req_tdata[MAIN_EN_BIT];
   assign sub_enable      = req_tdata[SUB_EN_BIT];
   assign half_enable     = req_tdata[HALF_EN_BIT];
   assign palette_address = req_tdata[PAL_ADDR_LSB +: INDEX_W];
   assign palette_data    = req_tdata[PAL_DATA_LSB +: COLOR_W];

   assign req_beat = req_tvalid && req_tready;
   assign is_blend = (req_tuser == CMD_BLEND);
   assign is_write = (req_tuser == CMD_PALETTE_WRITE);

   // an index past the palette reads as colour 0, a write there is dropped
   assign main_in_range = ({1'b0, main_index} < ENTRIES_LIM);
   assign sub_in_range  = ({1'b0, sub_index} < ENTRIES_LIM);
   assign addr_in_range = ({1'b0, palette_address} < ENTRIES_LIM);

   // ---------------------------------------------------------------- config port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_color_ff   <= '0;
         intensity_ff     <= '1;
         subtract_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIXED_COLOR:   fixed_color_ff   <= csr_data[COLOR_W-1:0];
            CSR_INTENSITY:     intensity_ff     <= csr_data[INTENSITY_W-1:0];
            CSR_SUBTRACT_MODE: subtract_mode_ff <= csr_data[0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // a stage loads when it is empty or the stage after it moves on
   assign adv3       = !rsp_tvalid || rsp_tready;
   assign adv2       = !s2_valid || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;

   // ---------------------------------------------------------------- stage 1
   pcmb_ram #(
      .DATA_W (COLOR_W),
      .DEPTH  (PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .wr_en     (req_beat && is_write && addr_in_range),
      .wr_addr   (palette_address[ADDR_W-1:0]),
      .wr_data   (palette_data),
      .rd_en     (req_beat && is_blend),
      .rd_addr_a (main_index[ADDR_W-1:0]),
      .rd_addr_b (sub_index[ADDR_W-1:0]),
      .rd_data_a (main_color),
      .rd_data_b (sub_color)
   );

   always_comb begin
      s1_valid_in         = req_tvalid && is_blend;
      // transparent sub pixel takes the fixed colour unless halving
      s1_ctl_in.use_fixed = (sub_index == '0) && !half_enable;
      s1_ctl_in.main_show = main_enable && main_in_range;
      s1_ctl_in.sub_show  = sub_enable && (s1_ctl_in.use_fixed || sub_in_range);
      s1_ctl_in.half      = half_enable;

      fixed_exp        = expand_color(fixed_color_ff);
      fixed_prod_in[0] = PROD_W'(fixed_exp.red) * PROD_W'(intensity_ff);
      fixed_prod_in[1] = PROD_W'(fixed_exp.green) * PROD_W'(intensity_ff);
      fixed_prod_in[2] = PROD_W'(fixed_exp.blue) * PROD_W'(intensity_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && s1_valid_in) begin
         s1_ctl_ff     <= s1_ctl_in;
         fixed_prod_ff <= fixed_prod_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   pcmb_operand u_operand (
      .clock      (clock),
      .reset      (reset),
      .load       (adv2),
      .in_valid   (s1_valid_ff),
      .in_ctl     (s1_ctl_ff),
      .main_color (main_color),
      .sub_color  (sub_color),
      .fixed_prod (fixed_prod_ff),
      .out_valid  (s2_valid),
      .main_rgb   (s2_main),
      .sub_rgb    (s2_sub)
   );

   // ---------------------------------------------------------------- stage 3
   pcmb_mixer u_mixer (
      .clock         (clock),
      .reset         (reset),
      .load          (adv3),
      .in_valid      (s2_valid),
      .subtract_mode (subtract_mode_ff),
      .main_rgb      (s2_main),
      .sub_rgb       (s2_sub),
      .out_valid     (rsp_tvalid),
      .out_rgb       (rsp_rgb)
   );

   assign rsp_tdata = rsp_rgb;

   // ---------------------------------------------------------------- checks
   // a palette write never enters the pixel pipeline
   a_write_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && is_write) |=> !s1_valid_ff)
      else $error("palette write entered the pixel pipeline");

   // an accepted blend beat always occupies stage 1 next cycle
   a_blend_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && is_blend) |=> s1_valid_ff)
      else $error("accepted blend beat lost at stage 1");

   // with every stage full and the receiver stalled, no new beat is taken
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("beat accepted while the pipeline is full and stalled");

endmodule
